FILE: rtl/qph_pkg.sv
// Shared constants, codes and controller/datapath signal bundles for the hash table.
package qph_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 31;
  localparam int SLOT_W = 4;
  localparam int MARK_W = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  // The home-slot remainder comes from a reciprocal multiply in the S_MOD state.
  localparam int RCP_W     = 32;
  localparam int MOD_STEPS = 2;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef struct packed {
    logic              load;
    logic              mod_step;
    logic              probe_init;
    logic              probe_adv;
    logic              cnt_inc;
    logic              clr_step;
    logic              mem_wr;
    logic [MARK_W-1:0] wr_mark;
    logic              res_we;
    logic              res_fail;
    logic              out_load;
  } qph_cmd_t;

  typedef struct packed {
    logic              mod_last;
    logic              clr_last;
    logic              op_valid;
    logic              is_insert;
    logic              is_delete;
    logic [MARK_W-1:0] mark;
    logic              key_eq;
    logic              probe_last;
    logic              out_busy;
  } qph_sts_t;

endpackage

FILE: rtl/qph_ifs.sv
// Request and response channel interfaces with valid/ready handshake.
interface qph_in_if;
  import qph_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [KEY_W-1:0]  key;
  modport source(output valid, opcode, key, input ready);
  modport sink(input valid, opcode, key, output ready);
endinterface

interface qph_out_if;
  import qph_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [SLOT_W-1:0] slot;
  modport source(output valid, status, slot, input ready);
  modport sink(input valid, status, slot, output ready);
endinterface

FILE: rtl/qph_dp.sv
// Datapath: slot memory, home-slot remainder unit, probe walker and result registers.
module qph_dp #(
  parameter int SLOTS = qph_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qph_pkg::qph_cmd_t           cmd,
  output qph_pkg::qph_sts_t           sts,
  input  logic [qph_pkg::OP_W-1:0]    in_opcode,
  input  logic [qph_pkg::KEY_W-1:0]   in_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_status,
  output logic [qph_pkg::SLOT_W-1:0]  out_slot
);
  import qph_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int EXT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int ENT_W  = MARK_W + KEY_W;
  localparam int RCP_SH = KEY_W + IDX_W;
  localparam int PROD_W = KEY_W + RCP_W;
  localparam logic [IDX_W:0]     SLOTS_C  = (IDX_W+1)'(SLOTS);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [63:0]        RCP_FULL = ((64'd1 << RCP_SH) + 64'(SLOTS - 1)) / 64'(SLOTS);
  localparam logic [RCP_W-1:0]   RECIP    = RCP_FULL[RCP_W-1:0];
  localparam logic [2*IDX_W-1:0] SLOTS_QM = (2*IDX_W)'(SLOTS);

  logic [OP_W-1:0]      op_r;
  logic [KEY_W-1:0]     key_r;
  logic [PROD_W-1:0]    prod;
  logic [IDX_W-1:0]     q_lo_r;
  logic [2*IDX_W-1:0]   qm_lo;
  logic [IDX_W-1:0]     rem_r;
  logic [IDX_W-1:0]     rem_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r;

  logic [IDX_W-1:0]     probe_pos_r;
  logic [IDX_W-1:0]     probe_pos_nxt;
  logic [IDX_W-1:0]     incr_r;
  logic [IDX_W-1:0]     incr_nxt;
  logic [IDX_W-1:0]     data_pos_r;
  logic [IDX_W-1:0]     eval_cnt_r;
  logic [IDX_W-1:0]     clr_cnt_r;
  logic [IDX_W:0]       pos_sum;
  logic [IDX_W:0]       pos_wrap;
  logic [IDX_W:0]       incr_sum;
  logic [IDX_W:0]       incr_wrap;

  logic [ENT_W-1:0]     mem [SLOTS];
  logic [ENT_W-1:0]     rd_data_r;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;

  logic                 res_fail_r;
  logic [IDX_W-1:0]     res_slot_r;
  logic [EXT_W-1:0]     res_slot_ext;
  logic                 out_valid_r;
  logic                 out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;

  // The quotient is the key times a scaled reciprocal of SLOTS, exact over the key range.
  // Only its low bits are kept, since the remainder fits in the index width.
  assign prod    = {{RCP_W{1'b0}}, key_r} * {{KEY_W{1'b0}}, RECIP};
  assign qm_lo   = {{IDX_W{1'b0}}, q_lo_r} * SLOTS_QM;
  assign rem_nxt = key_r[IDX_W-1:0] - qm_lo[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      key_r     <= in_key;
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      q_lo_r    <= prod[RCP_SH +: IDX_W];
      rem_r     <= rem_nxt;
      mod_cnt_r <= mod_cnt_r + MOD_CNT_W'(1);
    end
  end

  // Successive squares differ by odd numbers, so each probe adds the next odd step.
  assign pos_sum       = {1'b0, probe_pos_r} + {1'b0, incr_r};
  assign pos_wrap      = pos_sum - SLOTS_C;
  assign probe_pos_nxt = (pos_sum >= SLOTS_C) ? pos_wrap[IDX_W-1:0] : pos_sum[IDX_W-1:0];
  assign incr_sum      = {1'b0, incr_r} + (IDX_W+1)'(2);
  assign incr_wrap     = incr_sum - SLOTS_C;
  assign incr_nxt      = (incr_sum >= SLOTS_C) ? incr_wrap[IDX_W-1:0] : incr_sum[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      probe_pos_r <= rem_r;
      incr_r      <= IDX_W'(1);
      eval_cnt_r  <= '0;
    end else begin
      if (cmd.probe_adv) begin
        probe_pos_r <= probe_pos_nxt;
        incr_r      <= incr_nxt;
        data_pos_r  <= probe_pos_r;
      end
      if (cmd.cnt_inc) begin
        eval_cnt_r <= eval_cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
  end

  assign wr_en   = cmd.clr_step || cmd.mem_wr;
  assign wr_addr = cmd.clr_step ? clr_cnt_r : data_pos_r;
  assign wr_data = cmd.clr_step ? {MARK_EMPTY, {KEY_W{1'b0}}} : {cmd.wr_mark, key_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[probe_pos_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_fail_r <= cmd.res_fail;
      res_slot_r <= cmd.res_fail ? '0 : data_pos_r;
    end
  end

  assign res_slot_ext = EXT_W'(res_slot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_fail_r;
      out_slot_r   <= res_slot_ext[SLOT_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  always_comb begin
    sts.mod_last   = (mod_cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
    sts.clr_last   = (clr_cnt_r == LAST_IDX);
    sts.op_valid   = (op_r == OP_INSERT) || (op_r == OP_SEARCH) || (op_r == OP_DELETE);
    sts.is_insert  = (op_r == OP_INSERT);
    sts.is_delete  = (op_r == OP_DELETE);
    sts.mark       = rd_data_r[KEY_W +: MARK_W];
    sts.key_eq     = (rd_data_r[KEY_W-1:0] == key_r);
    sts.probe_last = (eval_cnt_r == LAST_IDX);
    sts.out_busy   = out_valid_r && !out_ready;
  end

endmodule

FILE: rtl/qph_ctrl.sv
// Controller state machine sequencing clearing, remainder, probing and result transfer.
module qph_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qph_pkg::qph_sts_t sts,
  output qph_pkg::qph_cmd_t cmd
);
  import qph_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_PRIME = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_PROBE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       found;
  logic       stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    if (sts.is_insert) begin
      found = (sts.mark != MARK_USED);
      stop  = 1'b0;
    end else begin
      found = (sts.mark == MARK_USED) && sts.key_eq;
      stop  = (sts.mark == MARK_EMPTY);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        if (sts.op_valid) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_FETCH;
        end else begin
          cmd.res_we   = 1'b1;
          cmd.res_fail = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_FETCH: begin
        cmd.probe_adv = 1'b1;
        state_nxt     = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe_adv = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (found) begin
          cmd.mem_wr   = sts.is_insert || sts.is_delete;
          cmd.wr_mark  = sts.is_insert ? MARK_USED : MARK_TOMB;
          cmd.res_we   = 1'b1;
          cmd.res_fail = 1'b0;
          state_nxt    = S_DONE;
        end else if (stop || sts.probe_last) begin
          cmd.res_we   = 1'b1;
          cmd.res_fail = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/quadratic_probe_hash_table_core.sv
// Top level of the open-addressed hash table with quadratic probing.
//
// Requests arrive on in_ch (opcode: insert, search or delete, and a 31-bit key);
// each request produces exactly one response on out_ch (status 0 done or 1 failed,
// and the slot index, 0 on failure). A transfer happens on a clock edge where
// valid and ready are both high.
// One request is processed at a time. After a request transfer the home slot is
// formed in the S_MOD state, S_PRIME and S_FETCH prime the slot memory read, then
// one slot is examined per cycle for up to SLOTS probes, and S_DONE passes the
// result to the output register once that register is free. An unused opcode is
// answered from S_PRIME without probing. The next request is taken in the cycle
// after the result is passed on. The probe loop is bounded by the single read port
// of the slot memory.
// The output register lets a new request be taken while the previous response
// waits; if the receiver stalls, the next response holds in the result registers
// until the output register frees up.
// After reset the slot memory is swept to empty, slot by slot, and in_ch.ready
// stays low until the sweep ends.
module quadratic_probe_hash_table_core #(
  parameter int SLOTS = qph_pkg::SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  qph_in_if.sink    in_ch,
  qph_out_if.source out_ch
);
  import qph_pkg::*;

  qph_cmd_t cmd;
  qph_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qph_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_opcode  (in_ch.opcode),
    .in_key     (in_ch.key),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_slot   (out_ch.slot)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the quadratic-probing hash table core.
`timescale 1ns / 1ps

module testbench;
  import qph_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FAIL = 1'b1;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASE_ITEMS = 150;
  localparam int CALM_TAIL = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic             typed;
    reply_t           want;
  } step_t;

  localparam int N_DIRECTED = 24;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{OP_SEARCH, 31'h00000000, 1'b1, '{ST_FAIL, 4'd0}},
    '{OP_DELETE, 31'h7FFFFFFF, 1'b1, '{ST_FAIL, 4'd0}},
    '{OP_UNUSED, 31'h7FFFFFFF, 1'b1, '{ST_FAIL, 4'd0}},
    '{OP_UNUSED, 31'h00000000, 1'b1, '{ST_FAIL, 4'd0}},
    '{OP_INSERT, 31'h00000000, 1'b1, '{ST_DONE, 4'd0}},
    '{OP_INSERT, 31'h7FFFFFFF, 1'b1, '{ST_DONE, 4'd15}},
    '{OP_SEARCH, 31'h7FFFFFFF, 1'b1, '{ST_DONE, 4'd15}},
    '{OP_INSERT, 31'h00000010, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_INSERT, 31'h00000020, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_INSERT, 31'h00000030, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_INSERT, 31'h00000040, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_SEARCH, 31'h00000040, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_SEARCH, 31'h00000030, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_DELETE, 31'h00000010, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_SEARCH, 31'h00000020, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_DELETE, 31'h00000010, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_INSERT, 31'h00000000, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_SEARCH, 31'h00000000, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_DELETE, 31'h00000000, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_SEARCH, 31'h00000000, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_INSERT, 31'h2AAAAAAA, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_SEARCH, 31'h55555555, 1'b0, '{ST_DONE, 4'd0}},
    '{OP_UNUSED, 31'h55555555, 1'b1, '{ST_FAIL, 4'd0}},
    '{OP_DELETE, 31'h7FFFFFFF, 1'b0, '{ST_DONE, 4'd0}}
  };

  logic clk;
  logic rst_n;

  qph_in_if  in_ch();
  qph_out_if out_ch();

  quadratic_probe_hash_table_core #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [KEY_W-1:0]  mirror_key  [SLOTS];
  logic [MARK_W-1:0] mirror_mark [SLOTS];
  logic [KEY_W-1:0]  key_pool [32];
  reply_t            pending_replies [$];
  int                fault_count = 0;
  int                idle_cycles = 0;
  bit                calm = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic reply_t apply_table_op(input logic [OP_W-1:0] op,
                                            input logic [KEY_W-1:0] key);
    reply_t r;
    int     home;
    int     s;
    int     j;
    bit     stop;
    r.status = ST_FAIL;
    r.slot = '0;
    home = int'(key % SLOTS);
    stop = 1'b0;
    for (j = 0; j < SLOTS && !stop; j++) begin
      s = (home + j * j) % SLOTS;
      if (op == OP_INSERT) begin
        if (mirror_mark[s] != MARK_USED) begin
          mirror_key[s] = key;
          mirror_mark[s] = MARK_USED;
          r.status = ST_DONE;
          r.slot = SLOT_W'(s);
          stop = 1'b1;
        end
      end else if (op == OP_SEARCH || op == OP_DELETE) begin
        if (mirror_mark[s] == MARK_EMPTY) begin
          stop = 1'b1;
        end else if (mirror_mark[s] == MARK_USED && mirror_key[s] == key) begin
          if (op == OP_DELETE) mirror_mark[s] = MARK_TOMB;
          r.status = ST_DONE;
          r.slot = SLOT_W'(s);
          stop = 1'b1;
        end
      end else begin
        stop = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic typed, input reply_t typed_reply);
    reply_t mirror;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key <= key;
    do @(posedge clk); while (!in_ch.ready);
    mirror = apply_table_op(op, key);
    pending_replies.push_back(typed ? typed_reply : mirror);
  endtask

  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 15) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected transfer, status %0d slot %0d", $time,
                 out_ch.status, out_ch.slot);
        fault_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   want.status, out_ch.status);
          fault_count++;
        end
        if (out_ch.slot !== want.slot) begin
          $display("%0t: slot mismatch, expected %0d, actual %0d", $time,
                   want.slot, out_ch.slot);
          fault_count++;
        end
      end
    end
  end

  initial begin
    int               i;
    int               k;
    int               r;
    int               pool_n;
    int               ins_w;
    int               home_base;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_INSERT;
    in_ch.key = '0;
    for (k = 0; k < SLOTS; k++) begin
      mirror_key[k] = '0;
      mirror_mark[k] = MARK_EMPTY;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      send_request(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].want);
    end

    pool_n = 1;
    ins_w = 40;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        pool_n = $urandom_range(2, 24);
        ins_w = $urandom_range(15, 60);
        home_base = $urandom_range(0, SLOTS - 1);
        for (k = 0; k < pool_n; k++) begin
          key_pool[k] = KEY_W'($urandom);
          if ($urandom_range(0, 1) == 1) key_pool[k][SLOT_W-1:0] = SLOT_W'(home_base);
        end
        calm = ((i / PHASE_ITEMS) % 4 == 3) || (i >= RANDOM_ITEMS - CALM_TAIL);
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = OP_UNUSED;
      end else if (r < 4 + ins_w) begin
        op = OP_INSERT;
      end else if ($urandom_range(0, 1) == 1) begin
        op = OP_SEARCH;
      end else begin
        op = OP_DELETE;
      end
      if ($urandom_range(0, 19) == 0) begin
        key = KEY_W'($urandom);
      end else begin
        key = key_pool[$urandom_range(0, pool_n - 1)];
      end
      send_request(op, key, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2 * SLOTS) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/qph_pkg.sv
rtl/qph_ifs.sv
rtl/qph_dp.sv
rtl/qph_ctrl.sv
rtl/quadratic_probe_hash_table_core.sv
tb/testbench.sv
